FILE: hw/rtl/jpp_pkg.sv
// ----------------------------------------------------------------------------
// JSON pretty printer package
// Shared character codes, beat descriptor and sequencer types.
// ----------------------------------------------------------------------------
package jpp_pkg;

	localparam int DEPTH_W       = 5;
	localparam int MAX_DEPTH_DEF = 16;
	localparam int QUEUE_DEPTH   = 2;
	localparam int QPTR_W        = 1;
	localparam int QCNT_W        = 2;

	localparam logic [7:0] CH_LBRACE    = 8'h7B;
	localparam logic [7:0] CH_LBRACKET  = 8'h5B;
	localparam logic [7:0] CH_RBRACE    = 8'h7D;
	localparam logic [7:0] CH_RBRACKET  = 8'h5D;
	localparam logic [7:0] CH_COMMA     = 8'h2C;
	localparam logic [7:0] CH_COLON     = 8'h3A;
	localparam logic [7:0] CH_QUOTE     = 8'h22;
	localparam logic [7:0] CH_BACKSLASH = 8'h5C;
	localparam logic [7:0] CH_NEWLINE   = 8'h0A;
	localparam logic [7:0] CH_SPACE     = 8'h20;

	typedef enum logic [1:0] {
		KIND_PLAIN,
		KIND_CLOSE,
		KIND_COMMA,
		KIND_COLON
	} jpp_kind_t;

	typedef enum logic [3:0] {
		PH_IDLE,
		PH_PRE_NL,
		PH_PRE_SP,
		PH_CL_NL,
		PH_CL_SP,
		PH_BYTE,
		PH_TAIL,
		PH_CM_SP,
		PH_POST_NL,
		PH_POST_SP
	} jpp_phase_t;

	typedef struct packed {
		logic [7:0]         data;
		jpp_kind_t          kind;
		logic               pre;
		logic               post;
		logic [DEPTH_W-1:0] d_pre;
		logic [DEPTH_W-1:0] d_b;
		logic               err;
		logic               last;
	} jpp_desc_t;

endpackage

FILE: hw/rtl/json_pretty_print_stream.sv
// An accepted item passes through the descriptor queue and the sequencer's output register.
// Throughput: the output sequencer emits one byte per cycle while dst_stall is low; an
// item produces from 1 up to 2*MAX_DEPTH+3 bytes.
// Input beats are taken each cycle while the two-entry descriptor queue has room.
// Reset (arst_n low) clears the queue, the sequencer and all text state at once.
// ----------------------------------------------------------------------------
// JSON pretty printer stream
// Reformats a JSON byte stream with newlines and indentation per nesting level.
// ----------------------------------------------------------------------------
module json_pretty_print_stream #(
	parameter int MAX_DEPTH = jpp_pkg::MAX_DEPTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       src_valid,
	output logic       src_stall,
	input  logic [7:0] in_byte,
	input  logic       last_byte,
	output logic       dst_valid,
	input  logic       dst_stall,
	output logic [7:0] out_byte,
	output logic       run_last,
	output logic       text_end,
	output logic       depth_error
);

	jpp_pkg::jpp_desc_t front_desc;
	jpp_pkg::jpp_desc_t head_desc;
	logic               accept;
	logic               full;
	logic               pop;
	logic               head_valid;

	assign src_stall = full;
	assign accept    = src_valid && !full;

	jpp_front #(
		.MAX_DEPTH(MAX_DEPTH)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.in_byte  (in_byte),
		.last_byte(last_byte),
		.desc     (front_desc)
	);

	jpp_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (accept),
		.push_desc (front_desc),
		.full      (full),
		.pop       (pop),
		.head_valid(head_valid),
		.head_desc (head_desc)
	);

	jpp_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_desc  (head_desc),
		.pop        (pop),
		.dst_valid  (dst_valid),
		.dst_stall  (dst_stall),
		.out_byte   (out_byte),
		.run_last   (run_last),
		.text_end   (text_end),
		.depth_error(depth_error)
	);

endmodule

FILE: hw/rtl/jpp_front.sv
// ----------------------------------------------------------------------------
// JSON pretty printer front end
// Classifies each input beat, updates string, depth and pending state, and
// builds one output descriptor per beat.
// ----------------------------------------------------------------------------
module jpp_front #(
	parameter int MAX_DEPTH = jpp_pkg::MAX_DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               accept,
	input  logic [7:0]         in_byte,
	input  logic               last_byte,
	output jpp_pkg::jpp_desc_t desc
);

	localparam logic [jpp_pkg::DEPTH_W-1:0] MAXD = jpp_pkg::DEPTH_W'(MAX_DEPTH);

	logic                        pend_q;
	logic                        str_q;
	logic [jpp_pkg::DEPTH_W-1:0] depth_q;
	logic [7:0]                  prev_q;
	logic                        seen_q;

	logic                        is_open;
	logic                        is_close;
	logic                        consumed;
	logic                        pre;
	logic                        post;
	logic                        new_pend;
	logic                        new_str;
	logic                        err;
	logic [jpp_pkg::DEPTH_W-1:0] dep1;
	logic [jpp_pkg::DEPTH_W-1:0] dep2;
	logic [jpp_pkg::DEPTH_W-1:0] dep3;
	jpp_pkg::jpp_kind_t          kind;

	assign is_open  = in_byte inside {jpp_pkg::CH_LBRACE, jpp_pkg::CH_LBRACKET};
	assign is_close = in_byte inside {jpp_pkg::CH_RBRACE, jpp_pkg::CH_RBRACKET};
	assign consumed = pend_q && is_close;
	assign pre      = pend_q && !is_close;

	always_comb begin
		err      = 1'b0;
		kind     = jpp_pkg::KIND_PLAIN;
		new_pend = 1'b0;
		new_str  = str_q;
		dep1     = depth_q;
		if (pre) begin
			if (depth_q >= MAXD) begin
				dep1 = MAXD;
				err  = 1'b1;
			end else begin
				dep1 = depth_q + jpp_pkg::DEPTH_W'(1);
			end
		end
		dep2 = dep1;
		if (!consumed) begin
			if (in_byte == jpp_pkg::CH_QUOTE) begin
				if (seen_q && prev_q != jpp_pkg::CH_BACKSLASH) begin
					new_str = !str_q;
				end
			end else if (str_q) begin
				kind = jpp_pkg::KIND_PLAIN;
			end else if (is_open) begin
				new_pend = 1'b1;
			end else if (is_close) begin
				kind = jpp_pkg::KIND_CLOSE;
				if (dep1 == '0) begin
					err = 1'b1;
				end else begin
					dep2 = dep1 - jpp_pkg::DEPTH_W'(1);
				end
			end else if (in_byte == jpp_pkg::CH_COMMA) begin
				kind = jpp_pkg::KIND_COMMA;
			end else if (in_byte == jpp_pkg::CH_COLON) begin
				kind = jpp_pkg::KIND_COLON;
			end
		end
		post = last_byte && new_pend;
		dep3 = dep2;
		if (post) begin
			if (dep2 >= MAXD) begin
				dep3 = MAXD;
				err  = 1'b1;
			end else begin
				dep3 = dep2 + jpp_pkg::DEPTH_W'(1);
			end
		end
	end

	always_comb begin
		desc.data  = in_byte;
		desc.kind  = kind;
		desc.pre   = pre;
		desc.post  = post;
		desc.d_pre = dep1;
		desc.d_b   = dep3;
		desc.err   = err;
		desc.last  = last_byte;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q  <= 1'b0;
			str_q   <= 1'b0;
			depth_q <= '0;
			prev_q  <= '0;
			seen_q  <= 1'b0;
		end else if (accept) begin
			if (last_byte) begin
				pend_q  <= 1'b0;
				str_q   <= 1'b0;
				depth_q <= '0;
				prev_q  <= '0;
				seen_q  <= 1'b0;
			end else begin
				pend_q  <= new_pend;
				str_q   <= new_str;
				depth_q <= dep3;
				prev_q  <= in_byte;
				seen_q  <= 1'b1;
			end
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) depth_q <= MAXD)
		else $error("nesting depth above its limit");
	assert property (@(posedge clk) disable iff (!arst_n)
		accept && last_byte |=> !pend_q && !str_q && depth_q == '0 && !seen_q)
		else $error("state not cleared after end of text");
	assert property (@(posedge clk) disable iff (!arst_n)
		pend_q |-> !str_q)
		else $error("open pending inside a string");

endmodule

FILE: hw/rtl/jpp_queue.sv
// ----------------------------------------------------------------------------
// JSON pretty printer descriptor queue
// Two-entry queue that decouples the front end from the output sequencer.
// ----------------------------------------------------------------------------
module jpp_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  jpp_pkg::jpp_desc_t push_desc,
	output logic               full,
	input  logic               pop,
	output logic               head_valid,
	output jpp_pkg::jpp_desc_t head_desc
);

	jpp_pkg::jpp_desc_t               entry_q [jpp_pkg::QUEUE_DEPTH];
	logic [jpp_pkg::QPTR_W-1:0]       wr_ptr_q;
	logic [jpp_pkg::QPTR_W-1:0]       rd_ptr_q;
	logic [jpp_pkg::QCNT_W-1:0]       count_q;

	assign full       = count_q == jpp_pkg::QCNT_W'(jpp_pkg::QUEUE_DEPTH);
	assign head_valid = count_q != '0;
	assign head_desc  = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_desc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + jpp_pkg::QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + jpp_pkg::QPTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + jpp_pkg::QCNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - jpp_pkg::QCNT_W'(1);
			end
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= jpp_pkg::QCNT_W'(jpp_pkg::QUEUE_DEPTH))
		else $error("queue count above its depth");
	assert property (@(posedge clk) disable iff (!arst_n) pop |-> head_valid)
		else $error("pop from an empty queue");
	assert property (@(posedge clk) disable iff (!arst_n) push |-> !full || pop)
		else $error("push into a full queue");

endmodule

FILE: hw/rtl/jpp_back.sv
// ----------------------------------------------------------------------------
// JSON pretty printer output sequencer
// Expands each descriptor into its output beats, one byte per cycle while
// the output is not stalled, into a registered output stage.
// ----------------------------------------------------------------------------
module jpp_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               head_valid,
	input  jpp_pkg::jpp_desc_t head_desc,
	output logic               pop,
	output logic               dst_valid,
	input  logic               dst_stall,
	output logic [7:0]         out_byte,
	output logic               run_last,
	output logic               text_end,
	output logic               depth_error
);

	logic                        active_q;
	jpp_pkg::jpp_desc_t          desc_q;
	jpp_pkg::jpp_phase_t         phase_q;
	logic [jpp_pkg::DEPTH_W-1:0] cnt_q;
	logic                        out_valid_q;
	logic [7:0]                  out_byte_q;
	logic                        run_last_q;
	logic                        text_end_q;
	logic                        depth_error_q;

	jpp_pkg::jpp_desc_t          cur_d;
	jpp_pkg::jpp_phase_t         cur_ph;
	jpp_pkg::jpp_phase_t         nxt_ph;
	jpp_pkg::jpp_phase_t         after_pre;
	logic [jpp_pkg::DEPTH_W-1:0] nxt_cnt;
	logic [7:0]                  emit_byte;
	logic                        adv;
	logic                        step;

	assign cur_d = active_q ? desc_q : head_desc;
	assign adv   = !out_valid_q || !dst_stall;
	assign step  = (active_q || head_valid) && adv;
	assign pop   = step && !active_q;

	always_comb begin
		if (active_q) begin
			cur_ph = phase_q;
		end else if (head_desc.pre) begin
			cur_ph = jpp_pkg::PH_PRE_NL;
		end else if (head_desc.kind == jpp_pkg::KIND_CLOSE) begin
			cur_ph = jpp_pkg::PH_CL_NL;
		end else begin
			cur_ph = jpp_pkg::PH_BYTE;
		end
	end

	always_comb begin
		after_pre = (cur_d.kind == jpp_pkg::KIND_CLOSE) ? jpp_pkg::PH_CL_NL : jpp_pkg::PH_BYTE;
		nxt_ph    = jpp_pkg::PH_IDLE;
		nxt_cnt   = cnt_q - jpp_pkg::DEPTH_W'(1);
		case (cur_ph)
			jpp_pkg::PH_PRE_NL: begin
				nxt_cnt = cur_d.d_pre;
				nxt_ph  = (cur_d.d_pre != '0) ? jpp_pkg::PH_PRE_SP : after_pre;
			end
			jpp_pkg::PH_PRE_SP: begin
				nxt_ph = (cnt_q == jpp_pkg::DEPTH_W'(1)) ? after_pre : jpp_pkg::PH_PRE_SP;
			end
			jpp_pkg::PH_CL_NL: begin
				nxt_cnt = cur_d.d_b;
				nxt_ph  = (cur_d.d_b != '0) ? jpp_pkg::PH_CL_SP : jpp_pkg::PH_BYTE;
			end
			jpp_pkg::PH_CL_SP: begin
				nxt_ph = (cnt_q == jpp_pkg::DEPTH_W'(1)) ? jpp_pkg::PH_BYTE : jpp_pkg::PH_CL_SP;
			end
			jpp_pkg::PH_BYTE: begin
				if (cur_d.kind inside {jpp_pkg::KIND_COMMA, jpp_pkg::KIND_COLON}) begin
					nxt_ph = jpp_pkg::PH_TAIL;
				end else if (cur_d.post) begin
					nxt_ph = jpp_pkg::PH_POST_NL;
				end
			end
			jpp_pkg::PH_TAIL: begin
				nxt_cnt = cur_d.d_b;
				if (cur_d.kind == jpp_pkg::KIND_COMMA && cur_d.d_b != '0) begin
					nxt_ph = jpp_pkg::PH_CM_SP;
				end
			end
			jpp_pkg::PH_CM_SP: begin
				nxt_ph = (cnt_q == jpp_pkg::DEPTH_W'(1)) ? jpp_pkg::PH_IDLE : jpp_pkg::PH_CM_SP;
			end
			jpp_pkg::PH_POST_NL: begin
				nxt_cnt = cur_d.d_b;
				nxt_ph  = (cur_d.d_b != '0) ? jpp_pkg::PH_POST_SP : jpp_pkg::PH_IDLE;
			end
			jpp_pkg::PH_POST_SP: begin
				nxt_ph = (cnt_q == jpp_pkg::DEPTH_W'(1)) ? jpp_pkg::PH_IDLE : jpp_pkg::PH_POST_SP;
			end
			default: begin
				nxt_ph = jpp_pkg::PH_IDLE;
			end
		endcase
	end

	always_comb begin
		case (cur_ph)
			jpp_pkg::PH_PRE_NL, jpp_pkg::PH_CL_NL, jpp_pkg::PH_POST_NL: begin
				emit_byte = jpp_pkg::CH_NEWLINE;
			end
			jpp_pkg::PH_TAIL: begin
				emit_byte = (cur_d.kind == jpp_pkg::KIND_COMMA) ?
					jpp_pkg::CH_NEWLINE : jpp_pkg::CH_SPACE;
			end
			jpp_pkg::PH_BYTE: begin
				emit_byte = cur_d.data;
			end
			default: begin
				emit_byte = jpp_pkg::CH_SPACE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q    <= 1'b0;
			phase_q     <= jpp_pkg::PH_IDLE;
			out_valid_q <= 1'b0;
		end else if (step) begin
			active_q    <= nxt_ph != jpp_pkg::PH_IDLE;
			phase_q     <= nxt_ph;
			out_valid_q <= 1'b1;
		end else if (adv) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			cnt_q         <= nxt_cnt;
			desc_q        <= cur_d;
			out_byte_q    <= emit_byte;
			run_last_q    <= nxt_ph == jpp_pkg::PH_IDLE;
			text_end_q    <= (nxt_ph == jpp_pkg::PH_IDLE) && cur_d.last;
			depth_error_q <= cur_d.err;
		end
	end

	assign dst_valid   = out_valid_q;
	assign out_byte    = out_byte_q;
	assign run_last    = run_last_q;
	assign text_end    = text_end_q;
	assign depth_error = depth_error_q;

	assert property (@(posedge clk) disable iff (!arst_n) active_q |-> phase_q != jpp_pkg::PH_IDLE)
		else $error("sequencer active without a phase");
	assert property (@(posedge clk) disable iff (!arst_n)
		active_q && (phase_q == jpp_pkg::PH_PRE_SP || phase_q == jpp_pkg::PH_CL_SP ||
		phase_q == jpp_pkg::PH_CM_SP || phase_q == jpp_pkg::PH_POST_SP) |-> cnt_q != '0)
		else $error("indent run with an empty count");
	assert property (@(posedge clk) disable iff (!arst_n) dst_valid && text_end |-> run_last)
		else $error("end of text not on the last beat of its run");
	assert property (@(posedge clk) disable iff (!arst_n) active_q |-> !pop)
		else $error("descriptor taken while another is in progress");

endmodule
